// ===== design/iafr_pkg.sv =====
// ----------------------------------------------------------------------------
// iafr_pkg
// Shared types and constants for the four-channel I2C ADC reader.
// ----------------------------------------------------------------------------
package iafr_pkg;

	localparam int CHANNEL_COUNT = 4;

	// register indexes on the configuration port
	localparam logic [1:0] REG_CONTROL = 2'd0;
	localparam logic [1:0] REG_ADDRESS = 2'd1;
	localparam logic [1:0] REG_RETRY   = 2'd2;

	localparam logic [7:0] CONTROL_RESET = 8'h04;
	localparam logic [6:0] ADDRESS_RESET = 7'd72;
	localparam logic [1:0] RETRY_RESET   = 2'd1;

	localparam logic OP_GO   = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [4:0] {
		STEP_IDLE       = 5'd0,
		STEP_START      = 5'd1,
		STEP_TX_WADDR   = 5'd2,
		STEP_ACK_WADDR  = 5'd3,
		STEP_TX_CTRL    = 5'd4,
		STEP_ACK_CTRL   = 5'd5,
		STEP_RS_PREP    = 5'd6,
		STEP_RS_FALL    = 5'd7,
		STEP_TX_RADDR   = 5'd8,
		STEP_ACK_RADDR  = 5'd9,
		STEP_RX_DUMMY   = 5'd10,
		STEP_MACK_DUMMY = 5'd11,
		STEP_RX_DATA    = 5'd12,
		STEP_MACK_DATA  = 5'd13,
		STEP_STOP_LOW   = 5'd14,
		STEP_STOP_RISE  = 5'd15,
		STEP_RSTOP_LOW  = 5'd16,
		STEP_RSTOP_RISE = 5'd17
	} step_t;

	// result item, last field in the lowest bits
	typedef struct packed {
		logic       error;
		logic       done_res;
		logic [7:0] data_byte;
		logic [1:0] channel;
		logic       data_valid;
		logic       busy_res;
		logic       sda_release;
		logic       scl_out;
	} result_t;

endpackage

// ===== design/i2c_adc_four_channel_reader_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_adc_four_channel_reader_unit
// I2C master sequencer that reads four channels from an 8-bit ADC, one bus
// phase per tick item.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  s_axis    | in        | tvalid/tready          | tuser opcode, tdata sda_in
//  m_axis    | out       | tvalid/tready          | tdata one result per item
//  apb       | in/out    | psel/penable, pready=1 | control, address, retry
//
// Every item gives one result: it waits in the input register, then the sequencer
// step writes the result register. A new item can be accepted every cycle unless
// m_axis stalls; the input register doubles as a skid stage, so one item is
// still taken while a result waits on m_axis.
// Reset clears the sequencer to idle and loads the register defaults.
module i2c_adc_four_channel_reader_unit
	import iafr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] sda_in, [7:1] zero
	input  logic        s_axis_tuser,   // [0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [0] scl_out, [1] sda_release, [2] busy_res,
	                                    // [3] data_valid, [5:4] channel,
	                                    // [13:6] data_byte, [14] done_res, [15] error
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] control_q;
	logic [6:0] address_q;
	logic [1:0] retry_limit_q;

	logic    valid_s1;
	logic    opcode_s1;
	logic    sda_s1;
	logic    out_valid_q;
	result_t out_q;
	logic    advance;

	step_t      step_q, step_d;
	logic       phase_q, phase_d;
	logic [3:0] count_q, count_d;
	logic [7:0] shift_q, shift_d;
	logic [2:0] index_q, index_d;
	logic [1:0] retries_q, retries_d;
	logic       err_flag_q, err_flag_d;
	result_t    res;

	logic       first;
	logic       clocked;
	logic [3:0] count_inc;
	logic [7:0] rx_byte;
	logic       last_byte;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q     <= CONTROL_RESET;
			address_q     <= ADDRESS_RESET;
			retry_limit_q <= RETRY_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_CONTROL: control_q     <= pwdata[7:0];
				REG_ADDRESS: address_q     <= pwdata[6:0];
				REG_RETRY:   retry_limit_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_CONTROL: prdata = {24'd0, control_q};
			REG_ADDRESS: prdata = {25'd0, address_q};
			REG_RETRY:   prdata = {30'd0, retry_limit_q};
			default:     prdata = 32'd0;
		endcase
	end

	// input register, drains whenever the result register is free
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			opcode_s1 <= s_axis_tuser;
			sda_s1    <= s_axis_tdata[0];
		end
	end

	// sequencer step
	assign first     = !phase_q;
	assign count_inc = count_q + 4'd1;
	assign rx_byte   = {shift_q[6:0], sda_s1};
	assign last_byte = (4'(index_q) + 4'd1) >= 4'(CHANNEL_COUNT);
	assign clocked   = (step_q != STEP_IDLE) && (step_q <= STEP_RSTOP_RISE) &&
	                   (step_q != STEP_START) && (step_q != STEP_RS_FALL) &&
	                   (step_q != STEP_STOP_RISE) && (step_q != STEP_RSTOP_RISE);

	always_comb begin
		step_d     = step_q;
		phase_d    = phase_q;
		count_d    = count_q;
		shift_d    = shift_q;
		index_d    = index_q;
		retries_d  = retries_q;
		err_flag_d = err_flag_q;
		res        = '0;
		res.scl_out     = 1'b1;
		res.sda_release = 1'b1;
		res.busy_res    = 1'b1;

		if (opcode_s1 == OP_GO) begin
			if (step_q == STEP_IDLE || step_q > STEP_RSTOP_RISE) begin
				retries_d  = 2'd0;
				err_flag_d = 1'b0;
				index_d    = 3'd0;
				count_d    = 4'd0;
				phase_d    = 1'b0;
				step_d     = STEP_START;
			end
		end else begin
			if (clocked) begin
				res.scl_out = !first;
				phase_d     = first;
			end
			case (step_q)
				STEP_START, STEP_RS_FALL: begin
					res.sda_release = 1'b0;
					shift_d = {address_q, step_q == STEP_RS_FALL};
					count_d = 4'd0;
					phase_d = 1'b0;
					step_d  = (step_q == STEP_START) ? STEP_TX_WADDR : STEP_TX_RADDR;
				end
				STEP_TX_WADDR, STEP_TX_CTRL, STEP_TX_RADDR: begin
					res.sda_release = shift_q[7];
					if (!first) begin
						shift_d = {shift_q[6:0], 1'b0};
						count_d = count_inc;
						if (count_inc >= 4'd8) begin
							count_d = 4'd0;
							case (step_q)
								STEP_TX_WADDR: step_d = STEP_ACK_WADDR;
								STEP_TX_CTRL:  step_d = STEP_ACK_CTRL;
								default:       step_d = STEP_ACK_RADDR;
							endcase
						end
					end
				end
				STEP_ACK_WADDR, STEP_ACK_CTRL, STEP_ACK_RADDR: begin
					if (!first) begin
						if (sda_s1) begin
							if (retries_q < retry_limit_q) begin
								retries_d = retries_q + 2'd1;
								step_d    = STEP_RSTOP_LOW;
							end else begin
								err_flag_d = 1'b1;
								step_d     = STEP_STOP_LOW;
							end
						end else if (step_q == STEP_ACK_WADDR) begin
							shift_d = control_q;
							step_d  = STEP_TX_CTRL;
						end else if (step_q == STEP_ACK_CTRL) begin
							step_d = STEP_RS_PREP;
						end else begin
							step_d = STEP_RX_DUMMY;
						end
					end
				end
				STEP_RS_PREP: begin
					if (!first) step_d = STEP_RS_FALL;
				end
				STEP_RX_DUMMY, STEP_RX_DATA: begin
					if (!first) begin
						shift_d = rx_byte;
						count_d = count_inc;
						if (count_inc >= 4'd8) begin
							count_d = 4'd0;
							if (step_q == STEP_RX_DATA) begin
								res.data_valid = 1'b1;
								res.channel    = index_q[1:0];
								res.data_byte  = rx_byte;
								step_d         = STEP_MACK_DATA;
							end else begin
								step_d = STEP_MACK_DUMMY;
							end
						end
					end
				end
				STEP_MACK_DUMMY: begin
					res.sda_release = 1'b0;
					if (!first) begin
						index_d = 3'd0;
						step_d  = STEP_RX_DATA;
					end
				end
				STEP_MACK_DATA: begin
					// the last byte is answered with a nack
					res.sda_release = last_byte;
					if (!first) begin
						if (last_byte) begin
							step_d = STEP_STOP_LOW;
						end else begin
							index_d = index_q + 3'd1;
							step_d  = STEP_RX_DATA;
						end
					end
				end
				STEP_STOP_LOW: begin
					res.sda_release = 1'b0;
					if (!first) step_d = STEP_STOP_RISE;
				end
				STEP_RSTOP_LOW: begin
					res.sda_release = 1'b0;
					if (!first) step_d = STEP_RSTOP_RISE;
				end
				STEP_STOP_RISE: begin
					res.done_res = 1'b1;
					res.error    = err_flag_q;
					res.busy_res = 1'b0;
					phase_d      = 1'b0;
					step_d       = STEP_IDLE;
				end
				STEP_RSTOP_RISE: begin
					phase_d = 1'b0;
					step_d  = STEP_START;
				end
				default: begin
					res.busy_res = 1'b0;
					phase_d      = 1'b0;
					step_d       = STEP_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= STEP_IDLE;
			phase_q    <= 1'b0;
			count_q    <= 4'd0;
			shift_q    <= 8'd0;
			index_q    <= 3'd0;
			retries_q  <= 2'd0;
			err_flag_q <= 1'b0;
		end else if (advance) begin
			step_q     <= step_d;
			phase_q    <= phase_d;
			count_q    <= count_d;
			shift_q    <= shift_d;
			index_q    <= index_d;
			retries_q  <= retries_d;
			err_flag_q <= err_flag_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// checks
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_q.done_res |-> !out_q.busy_res)
		else $error("done result still marked busy");

	a_input_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("item lost from input register");

	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == STEP_IDLE |-> !phase_q)
		else $error("idle sequencer with phase set");

	a_data_channel: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_q.data_valid |-> !out_q.error && !out_q.done_res)
		else $error("data byte on a finishing result");

endmodule

// ===== tb/i2c_adc_four_channel_reader_unit_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_adc_four_channel_reader_unit_tb
// Streams go requests and bus ticks into the reader and checks every result
// item against a cycle-free model of the I2C sequencer. Ticks are grouped into
// well-formed transactions with random ACK/NACK outcomes and random received
// bytes, across several register settings written over the APB port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_adc_four_channel_reader_unit_tb;
	import iafr_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int ITEM_TARGET = 1250;
	localparam int PRINT_LIMIT = 40;

	// how sda_in is chosen for a run of ticks
	localparam int SDA_LOW    = 0;
	localparam int SDA_HIGH   = 1;
	localparam int SDA_RANDOM = 2;

	typedef struct packed {
		logic op;
		logic sda;
	} bus_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	i2c_adc_four_channel_reader_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sequencer model state and register copies
	step_t      rd_step;
	logic       rd_phase;
	logic [3:0] rd_bits;
	logic [7:0] rd_shift;
	logic [2:0] rd_byte;
	logic [1:0] rd_retries;
	logic       rd_err;
	logic [7:0] cfg_control;
	logic [6:0] cfg_address;
	logic [1:0] cfg_retry;

	bus_item_t  tick_queue[$];
	result_t    expected_outputs[$];
	int         queued_items = 0;
	int         mismatches = 0;
	int         quiet_cycles = 0;
	int         send_gap = 0;
	int         stall_left = 0;
	bit         steady = 1'b0;
	bus_item_t  next_item;
	result_t    want_result;

	function automatic result_t reader_step(logic op, logic sda);
		result_t r;
		logic    first;
		logic    last;
		r = '0;
		r.scl_out = 1'b1;
		r.sda_release = 1'b1;
		r.busy_res = 1'b1;
		if (op == OP_GO) begin
			if (rd_step == STEP_IDLE) begin
				rd_retries = 2'd0;
				rd_err = 1'b0;
				rd_byte = 3'd0;
				rd_bits = 4'd0;
				rd_phase = 1'b0;
				rd_step = STEP_START;
			end
		end else begin
			first = !rd_phase;
			// two-tick steps drive scl low then high
			case (rd_step)
				STEP_IDLE, STEP_START, STEP_RS_FALL, STEP_STOP_RISE, STEP_RSTOP_RISE: ;
				default: begin
					r.scl_out = !first;
					rd_phase = first;
				end
			endcase
			case (rd_step)
				STEP_START: begin
					r.sda_release = 1'b0;
					rd_shift = {cfg_address, 1'b0};
					rd_bits = 4'd0;
					rd_phase = 1'b0;
					rd_step = STEP_TX_WADDR;
				end
				STEP_TX_WADDR, STEP_TX_CTRL, STEP_TX_RADDR: begin
					r.sda_release = rd_shift[7];
					if (!first) begin
						rd_shift = rd_shift << 1;
						rd_bits = rd_bits + 4'd1;
						if (rd_bits >= 4'd8) begin
							rd_bits = 4'd0;
							rd_step = step_t'(rd_step + 5'd1);
						end
					end
				end
				STEP_ACK_WADDR, STEP_ACK_CTRL, STEP_ACK_RADDR: begin
					if (!first) begin
						if (sda) begin
							if (rd_retries < cfg_retry) begin
								rd_retries = rd_retries + 2'd1;
								rd_step = STEP_RSTOP_LOW;
							end else begin
								rd_err = 1'b1;
								rd_step = STEP_STOP_LOW;
							end
						end else if (rd_step == STEP_ACK_WADDR) begin
							rd_shift = cfg_control;
							rd_step = STEP_TX_CTRL;
						end else if (rd_step == STEP_ACK_CTRL) begin
							rd_step = STEP_RS_PREP;
						end else begin
							rd_step = STEP_RX_DUMMY;
						end
					end
				end
				STEP_RS_PREP: begin
					if (!first)
						rd_step = STEP_RS_FALL;
				end
				STEP_RS_FALL: begin
					r.sda_release = 1'b0;
					rd_shift = {cfg_address, 1'b1};
					rd_bits = 4'd0;
					rd_phase = 1'b0;
					rd_step = STEP_TX_RADDR;
				end
				STEP_RX_DUMMY, STEP_RX_DATA: begin
					if (!first) begin
						rd_shift = {rd_shift[6:0], sda};
						rd_bits = rd_bits + 4'd1;
						if (rd_bits >= 4'd8) begin
							rd_bits = 4'd0;
							if (rd_step == STEP_RX_DATA) begin
								r.data_valid = 1'b1;
								r.channel = rd_byte[1:0];
								r.data_byte = rd_shift;
							end
							rd_step = step_t'(rd_step + 5'd1);
						end
					end
				end
				STEP_MACK_DUMMY: begin
					r.sda_release = 1'b0;
					if (!first) begin
						rd_byte = 3'd0;
						rd_step = STEP_RX_DATA;
					end
				end
				STEP_MACK_DATA: begin
					// last channel byte gets a nack
					last = (int'(rd_byte) + 1 >= CHANNEL_COUNT);
					r.sda_release = last;
					if (!first) begin
						if (last) begin
							rd_step = STEP_STOP_LOW;
						end else begin
							rd_byte = rd_byte + 3'd1;
							rd_step = STEP_RX_DATA;
						end
					end
				end
				STEP_STOP_LOW, STEP_RSTOP_LOW: begin
					r.sda_release = 1'b0;
					if (!first)
						rd_step = step_t'(rd_step + 5'd1);
				end
				STEP_STOP_RISE: begin
					r.done_res = 1'b1;
					r.error = rd_err;
					r.busy_res = 1'b0;
					rd_phase = 1'b0;
					rd_step = STEP_IDLE;
				end
				STEP_RSTOP_RISE: begin
					rd_phase = 1'b0;
					rd_step = STEP_START;
				end
				default: begin
					r.busy_res = 1'b0;
					rd_phase = 1'b0;
					rd_step = STEP_IDLE;
				end
			endcase
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic check_result(result_t got, result_t want);
		if (got.scl_out !== want.scl_out)
			report_mismatch("scl_out", int'(got.scl_out), int'(want.scl_out));
		if (got.sda_release !== want.sda_release)
			report_mismatch("sda_release", int'(got.sda_release), int'(want.sda_release));
		if (got.busy_res !== want.busy_res)
			report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
		if (got.data_valid !== want.data_valid)
			report_mismatch("data_valid", int'(got.data_valid), int'(want.data_valid));
		if (got.channel !== want.channel)
			report_mismatch("channel", int'(got.channel), int'(want.channel));
		if (got.data_byte !== want.data_byte)
			report_mismatch("data_byte", int'(got.data_byte), int'(want.data_byte));
		if (got.done_res !== want.done_res)
			report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
		if (got.error !== want.error)
			report_mismatch("error", int'(got.error), int'(want.error));
	endtask

	// input side: predict on every accepted item, then load the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_outputs.push_back(reader_step(s_axis_tuser, s_axis_tdata[0]));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (tick_queue.size() > 0) begin
					next_item = tick_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= next_item.op;
					s_axis_tdata <= {7'd0, next_item.sda};
					send_gap = pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: compare against the oldest prediction, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_outputs.size() == 0) begin
					report_mismatch("unexpected result", int'(m_axis_tdata), 0);
				end else begin
					want_result = expected_outputs.pop_front();
					check_result(result_t'(m_axis_tdata), want_result);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic push_item(logic op, logic sda);
		bus_item_t it;
		it.op = op;
		it.sda = sda;
		tick_queue.push_back(it);
		queued_items++;
	endtask

	// ticks inside a transaction, with the odd ignored go request mixed in
	task automatic push_ticks(int n, int mode);
		logic sda;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 2)
				push_item(OP_GO, 1'($urandom_range(1)));
			case (mode)
				SDA_LOW:  sda = 1'b0;
				SDA_HIGH: sda = 1'b1;
				default:  sda = 1'($urandom_range(1));
			endcase
			push_item(OP_TICK, sda);
		end
	endtask

	task automatic push_ack(input int nack_pct, output bit acked);
		acked = ($urandom_range(99) >= nack_pct);
		push_ticks(1, SDA_RANDOM);
		push_ticks(1, acked ? SDA_LOW : SDA_HIGH);
	endtask

	task automatic queue_transaction(int nack_pct, int data_mode);
		int tries;
		bit ok;
		bit finished;
		tries = 0;
		finished = 1'b0;
		push_item(OP_GO, 1'($urandom_range(1)));
		while (!finished) begin
			push_ticks(17, SDA_RANDOM);
			push_ack(nack_pct, ok);
			if (ok) begin
				push_ticks(16, SDA_RANDOM);
				push_ack(nack_pct, ok);
			end
			if (ok) begin
				// repeated start, read address
				push_ticks(19, SDA_RANDOM);
				push_ack(nack_pct, ok);
			end
			if (ok) begin
				push_ticks(18, SDA_RANDOM);
				for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
					push_ticks(16, data_mode);
					push_ticks(2, SDA_RANDOM);
				end
				push_ticks(3, SDA_RANDOM);
				finished = 1'b1;
			end else begin
				push_ticks(3, SDA_RANDOM);
				if (tries < cfg_retry)
					tries++;
				else
					finished = 1'b1;
			end
		end
	endtask

	task automatic apb_write(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CONTROL: cfg_control = value[7:0];
			REG_ADDRESS: cfg_address = value[6:0];
			REG_RETRY:   cfg_retry = value[1:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (tick_queue.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	initial begin : stimulus
		int phase;
		int pick;
		phase = 0;
		rd_step = STEP_IDLE;
		rd_phase = 1'b0;
		rd_bits = 4'd0;
		rd_shift = 8'd0;
		rd_byte = 3'd0;
		rd_retries = 2'd0;
		rd_err = 1'b0;
		cfg_control = CONTROL_RESET;
		cfg_address = ADDRESS_RESET;
		cfg_retry = RETRY_RESET;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// idle ticks, a go, a go while busy, and a nack that gives up at once
		apb_write(REG_RETRY, 32'd0);
		push_item(OP_TICK, 1'b0);
		push_item(OP_TICK, 1'b1);
		push_item(OP_GO, 1'b0);
		push_item(OP_GO, 1'b1);
		push_ticks(17, SDA_RANDOM);
		push_item(OP_TICK, 1'b0);
		push_item(OP_TICK, 1'b1);
		push_ticks(3, SDA_RANDOM);
		wait_idle();

		while (queued_items < ITEM_TARGET) begin
			case (phase % 4)
				0: begin
					apb_write(REG_CONTROL, 32'd0);
					apb_write(REG_ADDRESS, 32'd127);
				end
				1: begin
					apb_write(REG_CONTROL, 32'd255);
					apb_write(REG_ADDRESS, 32'd0);
				end
				default: begin
					apb_write(REG_CONTROL, $urandom_range(255));
					apb_write(REG_ADDRESS, $urandom_range(127));
				end
			endcase
			apb_write(REG_RETRY, phase % 4);
			steady = ($urandom_range(3) == 0);
			repeat (2) begin
				repeat ($urandom_range(2))
					push_item(OP_TICK, 1'($urandom_range(1)));
				pick = $urandom_range(2);
				queue_transaction(pick == 0 ? 0 : (pick == 1 ? 15 : 50),
					$urandom_range(2));
			end
			wait_idle();
			phase++;
		end

		if (expected_outputs.size() != 0)
			report_mismatch("results never arrived", expected_outputs.size(), 0);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
